// ----- src/spwm_pkg.sv -----
// Shared constants, types and the duty step function of the spindle PWM ramp sequencer.
`default_nettype none
package spwm_pkg;

  localparam int RAMP_TICKS = 10;
  localparam int RAMP_STEP  = 100;
  localparam int DUTY_FULL  = 1000;

  localparam int DUTY_W     = $clog2(DUTY_FULL + 1);
  localparam int RPM_W      = 16;
  localparam int WAIT_W     = 16;
  localparam int QUO_W      = RPM_W + DUTY_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int PHASE_W    = 3;

  // input item kinds
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RPM   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_REV = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PWR_DLY   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_DLY    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_DLY   = 3'd4;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PWR_WAIT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DIR_DOWN = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RAMP_UP  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ON_WAIT  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_OFF_DOWN = 3'd5;
  localparam logic [PHASE_W-1:0] PH_OFF_WAIT = 3'd6;

  typedef struct packed {
    logic load;
    logic div_step;
    logic apply;
  } spwm_cmd_t;

  typedef struct packed {
    logic in_is_on;
    logic div_last;
  } spwm_status_t;

  // one ramp step toward goal, clamped at goal
  function automatic logic [DUTY_W-1:0] step_toward(input logic [DUTY_W-1:0] duty,
                                                    input logic [DUTY_W-1:0] goal);
    logic [DUTY_W:0] up;
    logic [DUTY_W:0] diff;
    logic [DUTY_W-1:0] res;
    up   = {1'b0, duty} + (DUTY_W+1)'(RAMP_STEP);
    diff = {1'b0, duty} - {1'b0, goal};
    if (duty < goal) begin
      res = (up > {1'b0, goal}) ? goal : up[DUTY_W-1:0];
    end else if (duty > goal) begin
      res = (diff >= (DUTY_W+1)'(RAMP_STEP)) ? (duty - DUTY_W'(RAMP_STEP)) : goal;
    end else begin
      res = duty;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- src/spwm_ctrl.sv -----
// Handshake and sequencing controller: accept, divide (on items only), apply, present result.
`default_nettype none
module spwm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire spwm_pkg::spwm_status_t st,
  output spwm_pkg::spwm_cmd_t         cmd
);
  import spwm_pkg::*;

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_DIV   = 2'd1;
  localparam logic [1:0] C_APPLY = 2'd2;
  localparam logic [1:0] C_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_tready  = (state_r == C_IDLE);
  assign out_tvalid = (state_r == C_OUT);

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.apply    = 1'b0;
    case (state_r)
      C_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = st.in_is_on ? C_DIV : C_APPLY;
        end
      end
      C_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = C_APPLY;
      end
      C_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = C_OUT;
      end
      C_OUT: begin
        if (out_tready) state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- src/spwm_dp.sv -----
// Datapath: config registers, target divider, spindle state and result register.
`default_nettype none
module spwm_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [spwm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic [spwm_pkg::MODE_W-1:0]           in_tuser,
  input  wire logic [spwm_pkg::IN_DATA_W-1:0]        in_tdata,
  input  wire spwm_pkg::spwm_cmd_t                   cmd,
  output spwm_pkg::spwm_status_t                     st,
  output logic [spwm_pkg::OUT_DATA_W-1:0]            out_tdata
);
  import spwm_pkg::*;

  // configuration
  logic [RPM_W-1:0]  max_rpm_r;
  logic              allow_rev_r;
  logic [WAIT_W-1:0] pwr_dly_r, on_dly_r, off_dly_r;

  // latched item and divider
  logic [MODE_W-1:0]    mode_r;
  logic                 rev_r;
  logic [QUO_W-1:0]     quo_r;
  logic [RPM_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [RPM_W:0]       trial;
  logic                 trial_ge;
  logic [RPM_W:0]       trial_sub;
  logic [DUTY_W-1:0]    target;

  // spindle state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [DUTY_W-1:0]  tgt_r, tgt_nxt;
  logic               dir_r, dir_nxt;
  logic               dirp_r, dirp_nxt;
  logic               off_r, off_nxt;
  logic               pwr_r, pwr_nxt;
  logic [WAIT_W-1:0]  wc_r, wc_nxt;
  logic               rej;
  logic [OUT_DATA_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rpm_r   <= RPM_W'(3000);
      allow_rev_r <= 1'b0;
      pwr_dly_r   <= '0;
      on_dly_r    <= '0;
      off_dly_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_RPM:   max_rpm_r   <= cfg_wdata[RPM_W-1:0];
        REG_ALLOW_REV: allow_rev_r <= cfg_wdata[0];
        REG_PWR_DLY:   pwr_dly_r   <= cfg_wdata[WAIT_W-1:0];
        REG_ON_DLY:    on_dly_r    <= cfg_wdata[WAIT_W-1:0];
        REG_OFF_DLY:   off_dly_r   <= cfg_wdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign st.in_is_on = (in_tuser == MODE_ON);
  assign st.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // restoring divide, one quotient bit per cycle
  assign trial     = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge  = (trial >= {1'b0, max_rpm_r});
  assign trial_sub = trial - {1'b0, max_rpm_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      rev_r  <= in_tdata[0];
      quo_r  <= QUO_W'(in_tdata[RPM_W:1]) * QUO_W'(DUTY_FULL);
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[RPM_W-1:0] : trial[RPM_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], trial_ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign target = (max_rpm_r == '0 || quo_r > QUO_W'(DUTY_FULL)) ?
                  DUTY_W'(DUTY_FULL) : quo_r[DUTY_W-1:0];

  always_comb begin
    logic go_dir, go_ramp, go_ondly, go_offw, go_fin;
    go_dir    = 1'b0;
    go_ramp   = 1'b0;
    go_ondly  = 1'b0;
    go_offw   = 1'b0;
    go_fin    = 1'b0;
    phase_nxt = phase_r;
    duty_nxt  = duty_r;
    tgt_nxt   = tgt_r;
    dir_nxt   = dir_r;
    dirp_nxt  = dirp_r;
    off_nxt   = off_r;
    pwr_nxt   = pwr_r;
    wc_nxt    = wc_r;
    rej       = 1'b0;

    case (mode_r)
      MODE_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (wc_nxt != '0) wc_nxt = wc_nxt - 1'b1;
          if (wc_nxt == '0) begin
            case (phase_r)
              PH_PWR_WAIT: go_dir = 1'b1;
              PH_DIR_DOWN: begin
                if (duty_r != '0) begin
                  duty_nxt = step_toward(duty_r, '0);
                  wc_nxt   = WAIT_W'(RAMP_TICKS);
                end else go_ramp = 1'b1;
              end
              PH_RAMP_UP: begin
                if (duty_r != tgt_r) begin
                  duty_nxt = step_toward(duty_r, tgt_r);
                  wc_nxt   = WAIT_W'(RAMP_TICKS);
                end else go_ondly = 1'b1;
              end
              PH_ON_WAIT: begin
                off_nxt   = 1'b0;
                phase_nxt = PH_IDLE;
              end
              PH_OFF_DOWN: begin
                if (duty_r != '0) begin
                  duty_nxt = step_toward(duty_r, '0);
                  wc_nxt   = WAIT_W'(RAMP_TICKS);
                end else go_offw = 1'b1;
              end
              PH_OFF_WAIT: go_fin = 1'b1;
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      MODE_ON: begin
        if (phase_r != PH_IDLE || (rev_r && !allow_rev_r)) begin
          rej = 1'b1;
        end else begin
          dirp_nxt = rev_r;
          tgt_nxt  = target;
          if (off_r) begin
            pwr_nxt = 1'b1;
            if (pwr_dly_r != '0) begin
              wc_nxt    = pwr_dly_r;
              phase_nxt = PH_PWR_WAIT;
            end else go_dir = 1'b1;
          end else go_dir = 1'b1;
        end
      end
      MODE_OFF: begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else if (duty_r != '0) begin
          duty_nxt  = step_toward(duty_r, '0);
          wc_nxt    = WAIT_W'(RAMP_TICKS);
          phase_nxt = PH_OFF_DOWN;
        end else go_offw = 1'b1;
      end
      default: ;
    endcase

    // stage entries chain within one item, in sequence order
    if (go_dir) begin
      if (dirp_nxt != dir_nxt && duty_nxt != '0) begin
        duty_nxt  = step_toward(duty_nxt, '0);
        wc_nxt    = WAIT_W'(RAMP_TICKS);
        phase_nxt = PH_DIR_DOWN;
      end else go_ramp = 1'b1;
    end
    if (go_ramp) begin
      dir_nxt = dirp_nxt;
      if (duty_nxt == tgt_nxt) begin
        go_ondly = 1'b1;
      end else begin
        duty_nxt  = step_toward(duty_nxt, tgt_nxt);
        wc_nxt    = WAIT_W'(RAMP_TICKS);
        phase_nxt = PH_RAMP_UP;
      end
    end
    if (go_ondly) begin
      if (off_nxt && on_dly_r != '0) begin
        wc_nxt    = on_dly_r;
        phase_nxt = PH_ON_WAIT;
      end else begin
        off_nxt   = 1'b0;
        phase_nxt = PH_IDLE;
      end
    end
    if (go_offw) begin
      if (off_dly_r != '0) begin
        wc_nxt    = off_dly_r;
        phase_nxt = PH_OFF_WAIT;
      end else go_fin = 1'b1;
    end
    if (go_fin) begin
      pwr_nxt   = 1'b0;
      off_nxt   = 1'b1;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      duty_r  <= '0;
      tgt_r   <= '0;
      dir_r   <= 1'b0;
      dirp_r  <= 1'b0;
      off_r   <= 1'b1;
      pwr_r   <= 1'b0;
      wc_r    <= '0;
    end else if (cmd.apply) begin
      phase_r <= phase_nxt;
      duty_r  <= duty_nxt;
      tgt_r   <= tgt_nxt;
      dir_r   <= dir_nxt;
      dirp_r  <= dirp_nxt;
      off_r   <= off_nxt;
      pwr_r   <= pwr_nxt;
      wc_r    <= wc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_r <= {2'b00, rej, (phase_nxt != PH_IDLE), dir_nxt, pwr_nxt, duty_nxt};
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

// ----- src/spindle_pwm_ramp_sequencer_top.sv -----
// Tick and off items pass from the accepting state straight to the apply state; on items first
// run the 26-step shift-subtract divide that turns rpm into the duty target.
// One item in flight: a new item is accepted only once the last result has been taken.
// Reset (rst_n low, synchronous): spindle idle and off, duty 0, clockwise, power low,
// config back to max_rpm 3000, reverse disallowed, all delays 0.
// Top level of the spindle PWM ramp sequencer.
`default_nettype none
module spindle_pwm_ramp_sequencer_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [spwm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [0] want_reverse, [16:1] speed_rpm, [23:17] zero
  input  wire logic [spwm_pkg::IN_DATA_W-1:0]       in_tdata,
  // [1:0] mode
  input  wire logic [spwm_pkg::MODE_W-1:0]          in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [9:0] duty_permille, [10] power_enable, [11] reverse_out, [12] busy_res,
  // [13] rejected, [15:14] zero
  output logic [spwm_pkg::OUT_DATA_W-1:0]           out_tdata
);
  import spwm_pkg::*;

  spwm_cmd_t    cmd;
  spwm_status_t st;

  spwm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  spwm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
